/* sv/tmt_pkg.sv */
// Shared types, codes and sizes for the three-axis motion transform.
package tmt_pkg;

  // Default sizes for the top-level parameters
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 8;

  // Fixed result field and stream widths
  localparam int VALUE_BITS  = 35;
  localparam int OUT_DATA_W  = 40;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AXIS = 1'b1;

  // Transform selection
  typedef enum logic [2:0] {
    MODE_JERK   = 3'd0,
    MODE_MAGSQ  = 3'd1,
    MODE_MAG    = 3'd2,
    MODE_L1     = 3'd3,
    MODE_JMAGSQ = 3'd4,
    MODE_JMAG   = 3'd5,
    MODE_JL1    = 3'd6,
    MODE_MEDIAN = 3'd7
  } mode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ROOT,
    ST_EMIT,
    ST_TAIL
  } state_t;

  // Controls for the serial sum-of-squares unit
  typedef struct packed {
    logic load;
    logic step;
    logic squares;
  } sumsq_ctl_t;

  // Controls for the serial square-root unit
  typedef struct packed {
    logic load;
    logic step;
  } sqrt_ctl_t;

endpackage

/* sv/three_axis_motion_transform.sv */
// Top level: stream ports, history, sequencer and result queue of the motion transform.
//
// Use: samples enter on the in_ stream, one three-axis sample per transfer,
// in_tlast closing a window. Results leave on the out_ stream; out_tlast is
// set only on the zero result that follows the last sample of a window.
// The mode and axis registers are to be written through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
// Timing: one sample is processed at a time; in_tready is high while the
// sequencer is idle. Jerk and median results go straight to the emit step;
// the L1 modes pass through the sum step, the squared magnitude modes first
// run the radix-4 multiplier lanes, and the magnitude modes then the root,
// one bit per cycle. Jerk-based modes skip to emit on a window's first
// sample, and the last sample of a window adds a trailing result.
// Results go through a two-entry queue, so a stalled receiver does not hold
// off the next sample until that queue is full.
// Reset (rst_n low, synchronous) clears the sequencer, configuration and
// history registers and empties the queue.
module three_axis_motion_transform import tmt_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // sample_x, sample_y, sample_z from bit 0 up, zero padded to bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                   in_tlast,   // window_end
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // value in bits 34:0, zero padded
  output logic [OUT_DATA_W-1:0]                  out_tdata,
  output logic                                   out_tlast,  // run_end
  input  logic                                   cfg_we,
  input  logic [CFG_INDEX_W-1:0]                 cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int MS = (SB + 1) / 2;
  localparam int RB = SB + 1 + FRACTION_BITS;
  localparam int CW = $clog2(RB + 1);
  localparam int TW = 2 * SB + 2;

  // Registers
  state_t                state_r, state_nxt;
  mode_t                 mode_r;
  logic [1:0]            axis_r;
  logic signed [SB-1:0]  prev_r [3];
  logic signed [SB-1:0]  older_r;
  logic [1:0]            wpos_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  has_main_r, has_main_nxt;
  logic                  last_r, last_nxt;
  logic                  is_mag_r, is_mag_nxt;
  logic [VALUE_BITS-1:0] q_val_r  [2];
  logic                  q_last_r [2];
  logic [1:0]            q_cnt_r;

  // Datapath signals
  logic signed [SB-1:0]  cur  [3];
  logic signed [SB:0]    dif  [3];
  logic signed [SB:0]    vec  [3];
  logic signed [SB:0]    absf [3];
  logic [SB-1:0]         absv [3];
  logic [1:0]            ax;
  logic signed [SB-1:0]  med_a, med_b, med_c, med_lo, med_hi, med;
  logic                  jerk_vec;
  logic                  accept;
  logic                  push, pop, q_full, wr_idx;
  logic [VALUE_BITS-1:0] push_val;
  logic                  push_last;
  sumsq_ctl_t            sq_ctl;
  sqrt_ctl_t             rt_ctl;
  logic [TW-1:0]         total;
  logic [RB-1:0]         root;

  // Sample unpack, differences and magnitudes
  assign ax       = (axis_r == 2'd0) ? 2'd0 : ((axis_r == 2'd1) ? 2'd1 : 2'd2);
  assign jerk_vec = (mode_r == MODE_JMAGSQ) || (mode_r == MODE_JMAG) ||
                    (mode_r == MODE_JL1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cur[i]  = in_tdata[i*SB +: SB];
      dif[i]  = {cur[i][SB-1], cur[i]} - {prev_r[i][SB-1], prev_r[i]};
      vec[i]  = jerk_vec ? dif[i] : {cur[i][SB-1], cur[i]};
      absf[i] = vec[i][SB] ? -vec[i] : vec[i];
      absv[i] = absf[i][SB-1:0];
    end
  end

  // Three-tap median of the selected axis
  always_comb begin
    med_a  = older_r;
    med_b  = prev_r[ax];
    med_c  = cur[ax];
    med_lo = (med_a < med_b) ? med_a : med_b;
    med_hi = (med_a < med_b) ? med_b : med_a;
    if (med_c <= med_lo) begin
      med = med_lo;
    end else if (med_c >= med_hi) begin
      med = med_hi;
    end else begin
      med = med_c;
    end
  end

  // Arithmetic units
  tmt_sumsq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sumsq (
    .clk   (clk),
    .ctl   (sq_ctl),
    .abs_x (absv[0]),
    .abs_y (absv[1]),
    .abs_z (absv[2]),
    .total (total)
  );

  tmt_sqrt #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_sqrt (
    .clk      (clk),
    .ctl      (rt_ctl),
    .radicand (total),
    .root     (root)
  );

  // Sequencer: next state and unit controls
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    val_nxt      = val_r;
    has_main_nxt = has_main_r;
    last_nxt     = last_r;
    is_mag_nxt   = is_mag_r;
    in_tready    = 1'b0;
    sq_ctl       = '0;
    rt_ctl       = '0;
    push         = 1'b0;
    push_val     = '0;
    push_last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          last_nxt       = in_tlast;
          cnt_nxt        = '0;
          is_mag_nxt     = (mode_r == MODE_MAG) || (mode_r == MODE_JMAG);
          sq_ctl.load    = 1'b1;
          sq_ctl.squares = (mode_r == MODE_MAGSQ) || (mode_r == MODE_MAG) ||
                           (mode_r == MODE_JMAGSQ) || (mode_r == MODE_JMAG);
          val_nxt        = '0;
          case (mode_r)
            MODE_JERK: begin
              has_main_nxt = (wpos_r != 2'd0);
              val_nxt      = VALUE_BITS'(dif[ax]);
              state_nxt    = ST_EMIT;
            end
            MODE_MEDIAN: begin
              has_main_nxt = (wpos_r != 2'd1);
              if (wpos_r != 2'd0) begin
                val_nxt = VALUE_BITS'(med);
              end
              state_nxt = ST_EMIT;
            end
            MODE_MAGSQ, MODE_MAG: begin
              has_main_nxt = 1'b1;
              state_nxt    = ST_MUL;
            end
            MODE_L1: begin
              has_main_nxt = 1'b1;
              state_nxt    = ST_SUM;
            end
            MODE_JMAGSQ, MODE_JMAG: begin
              has_main_nxt = (wpos_r != 2'd0);
              state_nxt    = (wpos_r != 2'd0) ? ST_MUL : ST_EMIT;
            end
            MODE_JL1: begin
              has_main_nxt = (wpos_r != 2'd0);
              state_nxt    = (wpos_r != 2'd0) ? ST_SUM : ST_EMIT;
            end
            default: begin
              has_main_nxt = 1'b0;
              state_nxt    = ST_EMIT;
            end
          endcase
        end
      end
      ST_MUL: begin
        sq_ctl.step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CW'(MS - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (is_mag_r) begin
          rt_ctl.load = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_ROOT;
        end else begin
          val_nxt   = VALUE_BITS'(total);
          state_nxt = ST_EMIT;
        end
      end
      ST_ROOT: begin
        rt_ctl.step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CW'(RB - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!has_main_r) begin
          state_nxt = last_r ? ST_TAIL : ST_IDLE;
        end else if (!q_full) begin
          push      = 1'b1;
          push_val  = is_mag_r ? VALUE_BITS'(root) : val_r;
          state_nxt = last_r ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (!q_full) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // Sequencer and item registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      has_main_r <= 1'b0;
      last_r     <= 1'b0;
      is_mag_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      has_main_r <= has_main_nxt;
      last_r     <= last_nxt;
      is_mag_r   <= is_mag_nxt;
    end
    val_r <= val_nxt;
  end

  // Sample history and window position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
      end
      older_r <= '0;
      wpos_r  <= 2'd0;
    end else if (accept) begin
      older_r <= prev_r[ax];
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= cur[i];
      end
      if (in_tlast) begin
        wpos_r <= 2'd0;
      end else if (wpos_r != 2'd2) begin
        wpos_r <= wpos_r + 2'd1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_JERK;
      axis_r <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode_r <= mode_t'(cfg_data);
        CFG_AXIS: axis_r <= cfg_data[1:0];
        default:  ;
      endcase
    end
  end

  // Two-entry result queue, head at entry 0
  assign q_full     = (q_cnt_r == 2'd2);
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign wr_idx     = (q_cnt_r == 2'd1) && !pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
    // Head takes the new result, or the second entry moves up
    if (push && !wr_idx) begin
      q_val_r[0]  <= push_val;
      q_last_r[0] <= push_last;
    end else if (pop) begin
      q_val_r[0]  <= q_val_r[1];
      q_last_r[0] <= q_last_r[1];
    end
    if (push && wr_idx) begin
      q_val_r[1]  <= push_val;
      q_last_r[1] <= push_last;
    end
  end

  assign out_tdata = OUT_DATA_W'(q_val_r[0]);
  assign out_tlast = q_last_r[0];

endmodule

/* sv/tmt_sumsq.sv */
// Radix-4 serial sum of squares (or plain sum for L1) over three axis magnitudes.
module tmt_sumsq import tmt_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  sumsq_ctl_t               ctl,
  input  logic [SAMPLE_BITS-1:0]   abs_x,
  input  logic [SAMPLE_BITS-1:0]   abs_y,
  input  logic [SAMPLE_BITS-1:0]   abs_z,
  output logic [2*SAMPLE_BITS+1:0] total
);

  localparam int PW  = 2 * SAMPLE_BITS;        // one square
  localparam int MS  = (SAMPLE_BITS + 1) / 2;  // radix-4 digits
  localparam int MRW = 2 * MS;
  localparam int TW  = 2 * SAMPLE_BITS + 2;    // sum of three squares

  logic [SAMPLE_BITS-1:0] abs_in [3];
  logic [PW-1:0]          mc_r   [3];
  logic [PW-1:0]          m3_r   [3];
  logic [MRW-1:0]         mr_r   [3];
  logic [PW-1:0]          acc_r  [3];
  logic [PW-1:0]          addend [3];

  assign abs_in[0] = abs_x;
  assign abs_in[1] = abs_y;
  assign abs_in[2] = abs_z;

  // Partial product for the current multiplier digit of each lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (mr_r[i][1:0])
        2'd0:    addend[i] = '0;
        2'd1:    addend[i] = mc_r[i];
        2'd2:    addend[i] = mc_r[i] << 1;
        2'd3:    addend[i] = m3_r[i];
        default: addend[i] = '0;
      endcase
    end
  end

  // Lane registers: load operands, then one digit per step
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ctl.load) begin
        mc_r[i]  <= PW'(abs_in[i]);
        m3_r[i]  <= PW'(abs_in[i]) + (PW'(abs_in[i]) << 1);
        mr_r[i]  <= MRW'(abs_in[i]);
        acc_r[i] <= ctl.squares ? '0 : PW'(abs_in[i]);
      end else if (ctl.step) begin
        mc_r[i]  <= mc_r[i] << 2;
        m3_r[i]  <= m3_r[i] << 2;
        mr_r[i]  <= mr_r[i] >> 2;
        acc_r[i] <= acc_r[i] + addend[i];
      end
    end
  end

  // Final three-way sum
  assign total = TW'(acc_r[0]) + TW'(acc_r[1]) + TW'(acc_r[2]);

endmodule

/* sv/tmt_sqrt.sv */
// Digit-by-digit integer square root, one root bit per step, in fixed point.
module tmt_sqrt import tmt_pkg::*; #(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                                   clk,
  input  sqrt_ctl_t                              ctl,
  input  logic [2*SAMPLE_BITS+1:0]               radicand,
  output logic [SAMPLE_BITS+FRACTION_BITS:0]     root
);

  localparam int RB    = SAMPLE_BITS + 1 + FRACTION_BITS;
  localparam int RAD_W = 2 * RB;
  localparam int REM_W = RB + 2;

  logic [RAD_W-1:0] rad_r;
  logic [REM_W-1:0] rem_r;
  logic [RB-1:0]    root_r;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring down two radicand bits and try the next root bit
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rad_r  <= RAD_W'(radicand) << (2 * FRACTION_BITS);
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctl.step) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RB-2:0], fits};
    end
  end

  assign root = root_r;

endmodule
